// ===== design/lfu_cache_lru_tiebreak_top_assert.svh =====
// Assertion macros for the LFU cache block.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH

`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
	localparam int unsigned ENTRIES_DEF    = 16;
	localparam int unsigned COUNT_BITS_DEF = 16;
	localparam int unsigned KEY_W          = 32;
	localparam int unsigned VAL_W          = 32;
	localparam int unsigned STAMP_W        = 32;
	localparam int unsigned CAP_W          = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;
endpackage
`default_nettype wire

// ===== design/lfu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire lfu_pkg::status_t status,
	output lfu_pkg::cmd_t         cmd,
	output logic                  busy
);
	lfu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = lfu_pkg::ST_UPDATE;
				end
			end
			lfu_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = lfu_pkg::ST_IDLE;
			end
			default: begin
				state_d = lfu_pkg::ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== design/lfu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp #(
	parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lfu_pkg::cmd_t              cmd,
	output lfu_pkg::status_t                status,
	input  wire logic [lfu_pkg::CAP_W-1:0]  capacity_q,
	input  wire logic                       req_type,
	input  wire logic [lfu_pkg::KEY_W-1:0]  key,
	input  wire logic [lfu_pkg::VAL_W-1:0]  write_value,
	output logic                            done,
	output logic                            hit,
	output logic [lfu_pkg::VAL_W-1:0]       read_value
);
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned NW = $clog2(ENTRIES + 1);
	localparam int unsigned CW = (lfu_pkg::CAP_W > NW) ? lfu_pkg::CAP_W : NW;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic [ENTRIES-1:0]             valid_q;
	logic [lfu_pkg::KEY_W-1:0]      key_mem   [ENTRIES];
	logic [lfu_pkg::VAL_W-1:0]      val_mem   [ENTRIES];
	logic [COUNT_BITS-1:0]          cnt_mem   [ENTRIES];
	logic [lfu_pkg::STAMP_W-1:0]    stamp_mem [ENTRIES];

	logic                           put_q;
	logic [lfu_pkg::KEY_W-1:0]      key_q;
	logic [lfu_pkg::VAL_W-1:0]      wval_q;
	logic [lfu_pkg::STAMP_W-1:0]    clock_q;
	logic [IW-1:0]                  idx_q;
	logic                           found_q, free_ok_q, vic_ok_q;
	logic [IW-1:0]                  found_idx_q, free_idx_q, vic_idx_q;
	logic [NW-1:0]                  used_q;
	logic [COUNT_BITS-1:0]          vic_cnt_q;
	logic [lfu_pkg::STAMP_W-1:0]    vic_stamp_q;

	logic cur_v, cur_match, cur_better;
	assign cur_v      = valid_q[idx_q];
	assign cur_match  = cur_v && (key_mem[idx_q] == key_q);
	assign cur_better = !vic_ok_q || (cnt_mem[idx_q] < vic_cnt_q) ||
		((cnt_mem[idx_q] == vic_cnt_q) && (stamp_mem[idx_q] < vic_stamp_q));
	assign status.scan_done = (idx_q == LAST);

	logic [CW-1:0] cap_eff, used_ext;
	always_comb begin
		cap_eff  = CW'(capacity_q);
		used_ext = CW'(used_q);
		if (cap_eff > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			clock_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.update;
			if (cmd.update) begin
				clock_q <= clock_q + 1'b1;
				if (!found_q && put_q && cap_eff != '0) begin
					if (used_ext < cap_eff && free_ok_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			put_q     <= (req_type == lfu_pkg::REQ_PUT);
			key_q     <= key;
			wval_q    <= write_value;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			vic_ok_q  <= 1'b0;
			used_q    <= '0;
		end
		if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (cur_v) begin
				used_q <= used_q + 1'b1;
				if (cur_match && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_q;
				end
				if (cur_better) begin
					vic_ok_q    <= 1'b1;
					vic_idx_q   <= idx_q;
					vic_cnt_q   <= cnt_mem[idx_q];
					vic_stamp_q <= stamp_mem[idx_q];
				end
			end else if (!free_ok_q) begin
				free_ok_q  <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (cmd.update) begin
			hit        <= found_q;
			read_value <= '0;
			if (found_q) begin
				if (cnt_mem[found_idx_q] != CNT_MAX) begin
					cnt_mem[found_idx_q] <= cnt_mem[found_idx_q] + 1'b1;
				end
				stamp_mem[found_idx_q] <= clock_q;
				if (put_q) begin
					val_mem[found_idx_q] <= wval_q;
				end else begin
					read_value <= val_mem[found_idx_q];
				end
			end else if (put_q && cap_eff != '0) begin
				if (used_ext < cap_eff && free_ok_q) begin
					key_mem[free_idx_q]   <= key_q;
					val_mem[free_idx_q]   <= wval_q;
					cnt_mem[free_idx_q]   <= COUNT_BITS'(1);
					stamp_mem[free_idx_q] <= clock_q;
				end else if (vic_ok_q) begin
					key_mem[vic_idx_q]   <= key_q;
					val_mem[vic_idx_q]   <= wval_q;
					cnt_mem[vic_idx_q]   <= COUNT_BITS'(1);
					stamp_mem[vic_idx_q] <= clock_q;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/lfu_cache_lru_tiebreak_top.sv =====
// channel   signals                          beat taken when
// request   start req_type key write_value   start & !busy
// result    done hit read_value              done (one cycle, no stall)
// config    capacity_we capacity_wdata       capacity_we
// A request scans every slot, one slot per cycle through the
// scan unit, then takes an update step; done follows in the next cycle.
// busy stays high from the accepted beat until done.
// Reset clears valid marks, the access clock and done, and sets capacity to 16.
// The result cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_lru_tiebreak_top_assert.svh"
module lfu_cache_lru_tiebreak_top #(
	parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      req_type,
	input  wire logic [lfu_pkg::KEY_W-1:0] key,
	input  wire logic [lfu_pkg::VAL_W-1:0] write_value,
	output logic                           done,
	output logic                           hit,
	output logic [lfu_pkg::VAL_W-1:0]      read_value,
	input  wire logic                      capacity_we,
	input  wire logic [lfu_pkg::CAP_W-1:0] capacity_wdata
);
	logic [lfu_pkg::CAP_W-1:0] capacity_q;
	lfu_pkg::cmd_t    cmd;
	lfu_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.cmd(cmd), .busy(busy)
	);

	lfu_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.capacity_q(capacity_q), .req_type(req_type), .key(key),
		.write_value(write_value), .done(done), .hit(hit),
		.read_value(read_value)
	);

	`LFU_ASSERT_NEXT(a_update_done, clk, arst_n, cmd.update, done)
	`LFU_ASSERT_IMPL(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd))
	`LFU_ASSERT_IMPL(a_busy_cmd, clk, arst_n, cmd.scan || cmd.update, busy)
endmodule
`default_nettype wire

// ===== tb/lfu_cache_lru_tiebreak_top_tb.sv =====
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_top_tb;
	localparam int unsigned SLOTS = lfu_pkg::ENTRIES_DEF;
	localparam int unsigned LIMIT = 500000;
	localparam int unsigned POOL = 24;

	typedef logic [lfu_pkg::KEY_W-1:0]          key_t;
	typedef logic [lfu_pkg::VAL_W-1:0]          val_t;
	typedef logic [lfu_pkg::COUNT_BITS_DEF-1:0] count_t;
	typedef logic [lfu_pkg::STAMP_W-1:0]        stamp_t;
	typedef logic [lfu_pkg::CAP_W-1:0]          cap_t;

	typedef struct packed {
		logic hit;
		val_t value;
	} lookup_t;

	class lfu_scoreboard;
		logic      valid [SLOTS];
		key_t      keys [SLOTS];
		val_t      vals [SLOTS];
		count_t    uses [SLOTS];
		stamp_t    stamps [SLOTS];
		stamp_t    clock_now;
		cap_t      capacity;
		lookup_t   awaited_q[$];
		int        errors;

		function new();
			foreach (valid[i]) valid[i] = 1'b0;
			clock_now = '0;
			capacity = lfu_pkg::CAP_RESET;
			errors = 0;
		endfunction

		function void note_request(logic req, key_t k, val_t v);
			int found, free_slot, victim;
			int unsigned used, cap;
			lookup_t r;
			found = -1;
			free_slot = -1;
			victim = -1;
			used = 0;
			cap = (capacity > SLOTS) ? SLOTS : capacity;
			for (int i = 0; i < SLOTS; i++) begin
				if (valid[i]) begin
					used++;
					if (found < 0 && keys[i] == k)
						found = i;
					if (victim < 0 || uses[i] < uses[victim] ||
							(uses[i] == uses[victim] && stamps[i] < stamps[victim]))
						victim = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			r.hit = (found >= 0);
			r.value = '0;
			if (found >= 0) begin
				if (uses[found] != '1)
					uses[found]++;
				stamps[found] = clock_now;
				if (req == lfu_pkg::REQ_PUT)
					vals[found] = v;
				else
					r.value = vals[found];
			end else if (req == lfu_pkg::REQ_PUT && cap != 0) begin
				int s;
				s = (used < cap && free_slot >= 0) ? free_slot : victim;
				if (s >= 0) begin
					valid[s] = 1'b1;
					keys[s] = k;
					vals[s] = v;
					uses[s] = count_t'(1);
					stamps[s] = clock_now;
				end
			end
			clock_now++;
			awaited_q.push_back(r);
		endfunction

		function void check_result(logic h, val_t v);
			lookup_t e;
			if (awaited_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: hit=%0d read_value=%h", h, v);
				return;
			end
			e = awaited_q.pop_front();
			if (h !== e.hit || v !== e.value) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected hit=%0d read_value=%h, got hit=%0d read_value=%h",
						e.hit, e.value, h, v);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	key_t key;
	val_t write_value;
	logic done;
	logic hit;
	val_t read_value;
	logic capacity_we;
	cap_t capacity_wdata;

	lfu_scoreboard cache_sb;
	key_t          key_pool [POOL];

	lfu_cache_lru_tiebreak_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.write_value(write_value),
		.done(done),
		.hit(hit),
		.read_value(read_value),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("lfu_cache_lru_tiebreak_top test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			cache_sb.check_result(hit, read_value);
	end

	task automatic send_request(logic req, key_t k, val_t v);
		start <= 1'b1;
		req_type <= req;
		key <= k;
		write_value <= v;
		forever begin
			@(posedge clk);
			if (start && !busy)
				break;
		end
		cache_sb.note_request(req, k, v);
	endtask

	task automatic pause_sender(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (cache_sb.awaited_q.size() != 0);
		repeat (SLOTS + 4) @(posedge clk);
	endtask

	task automatic write_capacity(cap_t c);
		drain();
		capacity_we <= 1'b1;
		capacity_wdata <= c;
		@(posedge clk);
		cache_sb.capacity = c;
		capacity_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int unsigned count, bit quiet);
		key_t k;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, POOL - 1)];
			send_request(logic'($urandom_range(0, 1)), k, $urandom);
			if (!quiet && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 16));
		end
	endtask

	initial begin
		cap_t caps [8];
		caps = '{5'd3, 5'd16, 5'd0, 5'd1, 5'd31, 5'd7, 5'd2, 5'd16};
		cache_sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = lfu_pkg::REQ_GET;
		key = '0;
		write_value = '0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd16);
		send_request(lfu_pkg::REQ_PUT, '0, '0);
		send_request(lfu_pkg::REQ_PUT, '1, '1);
		send_request(lfu_pkg::REQ_GET, '0, '1);
		send_request(lfu_pkg::REQ_GET, '1, '0);
		send_request(lfu_pkg::REQ_GET, 32'h0001_2345, '0);
		send_request(lfu_pkg::REQ_PUT, '0, 32'ha5a5_a5a5);
		send_request(lfu_pkg::REQ_GET, '0, '0);
		write_capacity(5'd2);
		send_request(lfu_pkg::REQ_PUT, 32'h0000_00a0, 32'h1111_1111);
		send_request(lfu_pkg::REQ_PUT, 32'h0000_00b0, 32'h2222_2222);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00a0, '0);
		send_request(lfu_pkg::REQ_PUT, 32'h0000_00c0, 32'h3333_3333);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00b0, '0);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00c0, '0);
		send_request(lfu_pkg::REQ_PUT, 32'h0000_00d0, 32'h4444_4444);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00a0, '0);
		write_capacity(5'd0);
		send_request(lfu_pkg::REQ_PUT, 32'h0000_00e0, 32'h5555_5555);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00e0, '0);
		send_request(lfu_pkg::REQ_GET, 32'h0000_00d0, '0);

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			random_phase(180, 1'b0);
		end
		random_phase(300, 1'b1);

		drain();
		if (cache_sb.errors == 0)
			$display("lfu_cache_lru_tiebreak_top test passed");
		else
			$display("lfu_cache_lru_tiebreak_top test failed");
		$finish;
	end
endmodule
